>>> sv/hsog_pkg.sv
package hsog_pkg;

	// Fixed sampling and scaling constants
	localparam logic [15:0] MIN_READ_DELAY = 16'd100;
	localparam logic [16:0] NOISE_FLOOR_MA = 17'd500;
	localparam logic [15:0] FAULT_LEVEL    = 16'd30000;
	localparam logic [16:0] CUR_MAX        = 17'h1FFFF;
	localparam logic [7:0]  TRIP_MAX       = 8'hFF;
	localparam int          FRAC_BITS      = 16;
	localparam int          PROD_W         = 40;
	localparam int          CFG_DATA_W     = 24;
	localparam int          CFG_INDEX_W    = 3;

	// Channel states
	localparam logic [1:0] ST_OFF   = 2'd0;
	localparam logic [1:0] ST_ON    = 2'd1;
	localparam logic [1:0] ST_OC    = 2'd2;
	localparam logic [1:0] ST_FAULT = 2'd3;

	// Drive codes
	localparam logic [1:0] DRV_OFF    = 2'd0;
	localparam logic [1:0] DRV_STEADY = 2'd1;
	localparam logic [1:0] DRV_PWM    = 2'd2;

	// Retry modes; the unused code behaves as endless
	localparam logic [1:0] RETRY_NONE    = 2'd0;
	localparam logic [1:0] RETRY_COUNT   = 2'd1;
	localparam logic [1:0] RETRY_ENDLESS = 2'd2;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE       = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_NORMAL_LIMIT = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_INRUSH_LIMIT = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_INRUSH_WIN   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_RETRY_MODE   = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_RETRY_LIMIT  = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] CFG_RETRY_DELAY  = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] CFG_SENSE_SCALE  = 3'd7;

	typedef struct packed {
		logic        request_on;
		logic [31:0] now_ms;
		logic [15:0] sense_raw;
		logic        pwm_active;
		logic [15:0] pwm_count;
		logic [15:0] pwm_compare;
	} tick_t;

	typedef struct packed {
		logic [1:0]  drive_mode;
		logic [1:0]  channel_state;
		logic [16:0] load_current_ma;
		logic [7:0]  trip_count;
		logic        inrush_active;
	} report_t;

	typedef struct packed {
		logic        channel_enable;
		logic [16:0] normal_limit_ma;
		logic [16:0] inrush_limit_ma;
		logic [15:0] inrush_window_ms;
		logic [1:0]  retry_mode;
		logic [7:0]  retry_limit;
		logic [15:0] retry_delay_ms;
		logic [23:0] sense_scale;
	} cfg_t;

	// Sense path result handed to the state machine
	typedef struct packed {
		logic [16:0] load_ma;
		logic        hw_fault;
	} sense_t;

endpackage

>>> sv/hsog_window.sv
module hsog_window
	import hsog_pkg::*;
(
	input  tick_t tick,
	output logic  stable
);

	logic [17:0] count_x3;

	// cnt > compare/3 is the same as 3*cnt > compare, so no divider is needed
	assign count_x3 = {2'b00, tick.pwm_count} + {1'b0, tick.pwm_count, 1'b0};

	// Flag a counter value inside the stable part of the on phase
	assign stable = (tick.pwm_compare > MIN_READ_DELAY) &&
			(tick.pwm_count > MIN_READ_DELAY) &&
			(tick.pwm_count < tick.pwm_compare) &&
			(count_x3 > {2'b00, tick.pwm_compare});

endmodule

>>> sv/hsog_sense.sv
module hsog_sense
	import hsog_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  logic        enable,
	input  logic        on_state,
	input  logic        stable,
	input  tick_t       tick,
	input  logic [23:0] sense_scale,
	output sense_t      sense
);

	logic [15:0]       held_q;
	logic              gated;
	logic [15:0]       sample;
	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] rounded;
	logic [23:0]       scaled;
	logic [16:0]       sat_ma;

	// Hold the last stable sample while PWM drives the channel
	assign gated  = tick.pwm_active && on_state;
	assign sample = (gated && !stable) ? held_q : tick.sense_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (fire && enable && gated && stable) begin
			held_q <= tick.sense_raw;
		end
	end

	// Scale to milliamps, round half up, saturate, then apply the noise floor
	assign prod    = PROD_W'(sample) * PROD_W'(sense_scale);
	assign rounded = prod + (PROD_W'(1) << (FRAC_BITS - 1));
	assign scaled  = rounded[PROD_W-1:FRAC_BITS];
	assign sat_ma  = (scaled > 24'(CUR_MAX)) ? CUR_MAX : scaled[16:0];

	assign sense.load_ma  = (sat_ma <= NOISE_FLOOR_MA) ? '0 : sat_ma;
	assign sense.hw_fault = sample > FAULT_LEVEL;

endmodule

>>> sv/hsog_ctrl.sv
module hsog_ctrl
	import hsog_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  cfg_t    cfg,
	input  tick_t   tick,
	input  sense_t  sense,
	output logic    on_state,
	output report_t rpt
);

	logic [1:0]  mode_q, mode_d, start_mode;
	logic [7:0]  trip_q, trip_d;
	logic [31:0] son_q, son_d;
	logic [31:0] ttime_q, ttime_d;
	logic [31:0] since_on, since_trip;
	logic [16:0] limit;
	logic        inrush;
	logic        give_up;
	logic        retry_due;
	logic [1:0]  drive;

	// Wrap-safe elapsed times
	assign since_on   = tick.now_ms - son_q;
	assign since_trip = tick.now_ms - ttime_q;
	assign inrush     = since_on < {16'b0, cfg.inrush_window_ms};
	assign retry_due  = since_trip > {16'b0, cfg.retry_delay_ms};
	assign limit      = inrush ? cfg.inrush_limit_ma : cfg.normal_limit_ma;
	assign give_up    = (cfg.retry_mode == RETRY_NONE) ||
			((cfg.retry_mode == RETRY_COUNT) && (trip_q >= cfg.retry_limit));
	assign start_mode = sense.hw_fault ? ST_FAULT : mode_q;
	assign on_state   = mode_q == ST_ON;

	// Next state for the item in the input stage
	always_comb begin
		mode_d  = mode_q;
		trip_d  = trip_q;
		son_d   = son_q;
		ttime_d = ttime_q;
		drive   = DRV_OFF;
		if (!cfg.channel_enable) begin
			mode_d = ST_OFF;
			trip_d = '0;
		end else begin
			mode_d = start_mode;
			unique case (start_mode)
				ST_OFF: begin
					trip_d = '0;
					if (tick.request_on) begin
						son_d  = tick.now_ms;
						mode_d = ST_ON;
					end
				end
				ST_ON: begin
					drive = tick.pwm_active ? DRV_PWM : DRV_STEADY;
					if (!tick.request_on) begin
						mode_d = ST_OFF;
					end
					// Overcurrent beats the off request
					if (sense.load_ma > limit) begin
						ttime_d = tick.now_ms;
						if (trip_q != TRIP_MAX) begin
							trip_d = trip_q + 8'd1;
						end
						mode_d = ST_OC;
					end
				end
				ST_OC: begin
					if (give_up) begin
						mode_d = ST_FAULT;
					end else if (retry_due) begin
						son_d  = tick.now_ms;
						mode_d = ST_ON;
					end
					if (!tick.request_on) begin
						mode_d = ST_OFF;
					end
				end
				ST_FAULT: begin
					mode_d = ST_FAULT;
				end
			endcase
		end
	end

	// Advance the state on each transfer into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= ST_OFF;
			trip_q  <= '0;
			son_q   <= '0;
			ttime_q <= '0;
		end else if (fire) begin
			mode_q  <= mode_d;
			trip_q  <= trip_d;
			son_q   <= son_d;
			ttime_q <= ttime_d;
		end
	end

	// Build the result; a disabled channel reports zero current and no inrush
	always_comb begin
		rpt.drive_mode      = drive;
		rpt.channel_state   = mode_d;
		rpt.load_current_ma = cfg.channel_enable ? sense.load_ma : '0;
		rpt.trip_count      = trip_d;
		rpt.inrush_active   = cfg.channel_enable && inrush;
	end

endmodule

>>> sv/high_side_switch_overcurrent_guard.sv
// Channel   Handshake                    Payload
// tick      tick_valid / tick_ready      tick (tick_t)
// report    report_valid / report_ready  report (report_t)
// config    cfg_we                       cfg_index, cfg_data
//
// One tick per cycle while report_ready holds; ticks pass the input, then the result register.
// The input register feeds one pass of sample select, a 16x24 multiply and the state machine.
// arst_n clears the state machine, held sample, configuration and both valid flags.
// A stalled report holds in the result register while the next tick waits in the input register.
module high_side_switch_overcurrent_guard
	import hsog_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   tick_valid,
	output logic                   tick_ready,
	input  tick_t                  tick,
	output logic                   report_valid,
	input  logic                   report_ready,
	output report_t                report,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t    cfg_q;
	tick_t   tick_s1;
	logic    stable_s1;
	logic    valid_s1;
	logic    stable;
	logic    fire;
	logic    on_state;
	logic    out_valid_q;
	report_t report_q;
	report_t rpt;
	sense_t  sense;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ENABLE:       cfg_q.channel_enable   <= cfg_data[0];
				CFG_NORMAL_LIMIT: cfg_q.normal_limit_ma  <= cfg_data[16:0];
				CFG_INRUSH_LIMIT: cfg_q.inrush_limit_ma  <= cfg_data[16:0];
				CFG_INRUSH_WIN:   cfg_q.inrush_window_ms <= cfg_data[15:0];
				CFG_RETRY_MODE:   cfg_q.retry_mode       <= cfg_data[1:0];
				CFG_RETRY_LIMIT:  cfg_q.retry_limit      <= cfg_data[7:0];
				CFG_RETRY_DELAY:  cfg_q.retry_delay_ms   <= cfg_data[15:0];
				CFG_SENSE_SCALE:  cfg_q.sense_scale      <= cfg_data[23:0];
			endcase
		end
	end

	hsog_window u_window (
		.tick   (tick),
		.stable (stable)
	);

	// Flow control: the input stage moves on when the result register is empty or being read out
	assign fire       = valid_s1 && (!out_valid_q || report_ready);
	assign tick_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick_ready) begin
			valid_s1 <= tick_valid;
		end
	end

	// Capture the tick and its precomputed window flag
	always_ff @(posedge clk) begin
		if (tick_valid && tick_ready) begin
			tick_s1   <= tick;
			stable_s1 <= stable;
		end
	end

	hsog_sense u_sense (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.enable      (cfg_q.channel_enable),
		.on_state    (on_state),
		.stable      (stable_s1),
		.tick        (tick_s1),
		.sense_scale (cfg_q.sense_scale),
		.sense       (sense)
	);

	hsog_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.cfg      (cfg_q),
		.tick     (tick_s1),
		.sense    (sense),
		.on_state (on_state),
		.rpt      (rpt)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (report_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			report_q <= rpt;
		end
	end

	assign report_valid = out_valid_q;
	assign report       = report_q;

`ifndef SYNTH
	a_fault_drive_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && report_q.channel_state == ST_FAULT |-> report_q.drive_mode == DRV_OFF)
		else $error("fault state reported with drive on");

	a_drive_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> report_q.drive_mode != 2'd3)
		else $error("undefined drive code");

	a_noise_floor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && report_q.load_current_ma != '0 |->
		report_q.load_current_ma > NOISE_FLOOR_MA)
		else $error("current below noise floor not suppressed");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!tick_ready |-> valid_s1 && out_valid_q && !report_ready)
		else $error("input stalled without a blocked result");

	a_off_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !cfg_q.channel_enable |=>
		report_q.channel_state == ST_OFF && report_q.trip_count == '0)
		else $error("disabled channel not forced off");
`endif

endmodule
